FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/lprd_pkg.sv
// ---------------------------------------------------------------------------
// lprd_pkg
// Types and constants for the length-prefixed record deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package lprd_pkg;

  localparam int HDR_LEN   = 6;
  localparam int LEN_BYTES = 4;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 32;
  localparam int Q_DEPTH   = 4;
  localparam int QA_W      = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_LENGTH     = 3'd1,
    PH_PAYLOAD    = 3'd2,
    PH_IGNORE     = 3'd3,
    PH_BAD_HEADER = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_BYTE       = 3'd0,
    KIND_EMPTY      = 3'd1,
    KIND_OK         = 3'd2,
    KIND_BAD_HEADER = 3'd3,
    KIND_TRUNCATED  = 3'd4
  } kind_t;

  typedef struct packed {
    logic              has_byte;
    logic [BYTE_W-1:0] stream_byte;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] payload;
    logic              record_end;
    logic [CNT_W-1:0]  record_number;
  } out_item_t;

  // Results produced by one accepted request, data result ahead of status.
  typedef struct packed {
    logic      byte_v;
    out_item_t byte_res;
    logic      stat_v;
    out_item_t stat_res;
  } push_t;

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [2:0] pos);
    logic [BYTE_W-1:0] b;
    unique case (pos)
      3'd0:    b = 8'h4D;
      3'd1:    b = 8'h53;
      3'd2:    b = 8'h4D;
      3'd3:    b = 8'h50;
      3'd4:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lprd_core.sv
// ---------------------------------------------------------------------------
// lprd_core
// Stream state and result generation, one request per cycle while acc is high.
// ---------------------------------------------------------------------------
`default_nettype none

module lprd_core
  import lprd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire in_item_t         item,
  input  wire logic [CNT_W-1:0] max_records,
  output push_t                 push
);

  `include "assert_macros.svh"

  phase_t             phase_r, phase_nxt, ph_mid;
  logic [2:0]         hdr_pos_r, hdr_pos_nxt, hdr_pos_mid;
  logic [2:0]         len_seen_r, len_seen_nxt, len_seen_mid;
  logic [CNT_W-1:0]   len_shift_r, len_shift_nxt, len_shift_mid;
  logic [CNT_W-1:0]   pay_left_r, pay_left_nxt, pay_left_mid;
  logic [CNT_W-1:0]   rec_done_r, rec_done_nxt, rec_done_mid;

  logic [CNT_W-1:0]   shifted, left_dec, rec_inc;
  logic               len_done, limit_hit;
  logic [BYTE_W-1:0]  b;
  kind_t              stat_kind;

  assign b         = item.stream_byte;
  assign shifted   = {len_shift_r[CNT_W-BYTE_W-1:0], b};
  assign len_done  = (len_seen_r == 3'(LEN_BYTES-1));
  assign left_dec  = pay_left_r - 1'b1;
  assign rec_inc   = rec_done_r + 1'b1;
  assign limit_hit = (max_records != '0) && (rec_inc >= max_records);

  // State after the byte, before end of stream is applied
  always_comb begin
    ph_mid        = phase_r;
    hdr_pos_mid   = hdr_pos_r;
    len_seen_mid  = len_seen_r;
    len_shift_mid = len_shift_r;
    pay_left_mid  = pay_left_r;
    rec_done_mid  = rec_done_r;
    if (item.has_byte) begin
      unique case (phase_r)
        PH_HEADER: begin
          if ((hdr_pos_r < 3'(HDR_LEN)) && (b == hdr_byte(hdr_pos_r))) begin
            hdr_pos_mid = hdr_pos_r + 1'b1;
            if (hdr_pos_r == 3'(HDR_LEN-1)) begin
              ph_mid        = PH_LENGTH;
              len_seen_mid  = '0;
              len_shift_mid = '0;
              pay_left_mid  = '0;
            end
          end else begin
            ph_mid = PH_BAD_HEADER;
          end
        end
        PH_LENGTH: begin
          len_shift_mid = shifted;
          len_seen_mid  = len_seen_r + 1'b1;
          if (len_done) begin
            pay_left_mid = shifted;
            if (shifted == '0) begin
              rec_done_mid  = rec_inc;
              len_seen_mid  = '0;
              len_shift_mid = '0;
              pay_left_mid  = '0;
              ph_mid        = limit_hit ? PH_IGNORE : PH_LENGTH;
            end else begin
              ph_mid = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pay_left_mid = left_dec;
          if (left_dec == '0) begin
            rec_done_mid  = rec_inc;
            len_seen_mid  = '0;
            len_shift_mid = '0;
            ph_mid        = limit_hit ? PH_IGNORE : PH_LENGTH;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (item.end_of_stream) begin
      phase_nxt     = PH_HEADER;
      hdr_pos_nxt   = '0;
      len_seen_nxt  = '0;
      len_shift_nxt = '0;
      pay_left_nxt  = '0;
      rec_done_nxt  = '0;
    end else begin
      phase_nxt     = ph_mid;
      hdr_pos_nxt   = hdr_pos_mid;
      len_seen_nxt  = len_seen_mid;
      len_shift_nxt = len_shift_mid;
      pay_left_nxt  = pay_left_mid;
      rec_done_nxt  = rec_done_mid;
    end
  end

  // Results of this request
  always_comb begin
    push = '0;
    push.byte_res.kind          = KIND_BYTE;
    push.byte_res.record_number = rec_done_r;
    if (item.has_byte && (phase_r == PH_PAYLOAD)) begin
      push.byte_v              = acc;
      push.byte_res.payload    = b;
      push.byte_res.record_end = (left_dec == '0);
    end else if (item.has_byte && (phase_r == PH_LENGTH) && len_done && (shifted == '0)) begin
      push.byte_v              = acc;
      push.byte_res.kind       = KIND_EMPTY;
      push.byte_res.record_end = 1'b1;
    end
    push.stat_v                 = acc && item.end_of_stream;
    push.stat_res.kind          = stat_kind;
    push.stat_res.record_number = rec_done_mid;
  end

  always_comb begin
    priority if ((ph_mid == PH_HEADER) || (ph_mid == PH_BAD_HEADER)) begin
      stat_kind = KIND_BAD_HEADER;
    end else if (ph_mid == PH_PAYLOAD) begin
      stat_kind = KIND_TRUNCATED;
    end else if ((ph_mid == PH_LENGTH) && (len_seen_mid != '0)) begin
      stat_kind = KIND_TRUNCATED;
    end else begin
      stat_kind = KIND_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_pos_r   <= '0;
      len_seen_r  <= '0;
      len_shift_r <= '0;
      pay_left_r  <= '0;
      rec_done_r  <= '0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      len_seen_r  <= len_seen_nxt;
      len_shift_r <= len_shift_nxt;
      pay_left_r  <= pay_left_nxt;
      rec_done_r  <= rec_done_nxt;
    end
  end

  `ASSERT_IMPL(a_payload_nonzero, clk, rst_n, phase_r == PH_PAYLOAD, pay_left_r != '0)
  `ASSERT_IMPL(a_header_no_records, clk, rst_n, phase_r == PH_HEADER, rec_done_r == '0)

endmodule

`default_nettype wire

FILE: rtl/lprd_outq.sv
// ---------------------------------------------------------------------------
// lprd_outq
// Small result queue: up to two writes per cycle, one read per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module lprd_outq
  import lprd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_item
);

  `include "assert_macros.svh"

  out_item_t         mem [Q_DEPTH];
  logic [QA_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [QA_W:0]     cnt_r, cnt_nxt;
  logic              pop, two;
  logic [1:0]        n_push;
  out_item_t         first;

  assign two     = push.byte_v && push.stat_v;
  assign n_push  = 2'(push.byte_v) + 2'(push.stat_v);
  assign first   = push.byte_v ? push.byte_res : push.stat_res;
  assign wr_p1   = wr_r + 1'b1;
  assign pop     = out_valid && out_ready;
  assign wr_nxt  = wr_r + QA_W'(n_push);
  assign rd_nxt  = rd_r + QA_W'(pop);
  assign cnt_nxt = cnt_r + (QA_W+1)'(n_push) - (QA_W+1)'(pop);

  assign out_valid = (cnt_r != '0);
  assign out_item  = mem[rd_r];
  assign room      = (cnt_r <= (QA_W+1)'(Q_DEPTH-2));

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_r] <= first;
    end
    if (two) begin
      mem[wr_p1] <= push.stat_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= (QA_W+1)'(Q_DEPTH))
  `ASSERT_ALWAYS(a_ptr_cnt, clk, rst_n, QA_W'(wr_r - rd_r) == cnt_r[QA_W-1:0])

endmodule

`default_nettype wire

FILE: rtl/length_prefixed_record_deframer.sv
// ---------------------------------------------------------------------------
// length_prefixed_record_deframer
// Header check and big-endian length-prefixed record splitting of a byte stream.
// ---------------------------------------------------------------------------
// A request is taken whenever in_valid is high and the queue has room. Its
// results are written into a four-entry output queue and leave it in order,
// one result per cycle while out_ready is high; a request that carries both a
// byte and end of stream gives two results. in_ready drops only while fewer
// than two queue entries are free, which can happen even with out_ready held
// high, since the queue's single read port drains one result per cycle.
// The user must write max_records through cfg only while the block is idle;
// the block itself does not enforce this. cfg_ready is always high.
`default_nettype none

module length_prefixed_record_deframer
  import lprd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] max_records_r;
  logic             acc, room;
  push_t            push;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign acc       = in_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_records_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_records_r <= cfg_data;
    end
  end

  lprd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .item        (in_item),
    .max_records (max_records_r),
    .push        (push)
  );

  lprd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: dv/length_prefixed_record_deframer_checker.sv
// ---------------------------------------------------------------------------
// length_prefixed_record_deframer_checker
// Watches the request, result and register channels of the deframer, keeps
// its own copy of the header, length and payload state, predicts the results
// of every accepted request and compares each accepted result with the
// oldest prediction. Hands the failure count and the number of outstanding
// predictions to the testbench top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_record_deframer_checker
  import lprd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_item,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam logic [47:0] MAGIC = 48'h4D534D503100;

  phase_t           st_phase;
  logic [2:0]       hdr_pos;
  logic [2:0]       len_seen;
  logic [31:0]      len_acc;
  logic [31:0]      bytes_left;
  logic [31:0]      rec_count;
  logic [31:0]      rec_limit;

  out_item_t        expected_results [$];
  out_item_t        want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_stream_state();
    st_phase   = PH_HEADER;
    hdr_pos    = 3'd0;
    len_seen   = 3'd0;
    len_acc    = 32'd0;
    bytes_left = 32'd0;
    rec_count  = 32'd0;
  endtask

  task automatic next_record();
    len_seen   = 3'd0;
    len_acc    = 32'd0;
    bytes_left = 32'd0;
    if (rec_limit != 32'd0 && rec_count >= rec_limit) st_phase = PH_IGNORE;
    else st_phase = PH_LENGTH;
  endtask

  task automatic add_result(input kind_t k, input logic [7:0] b, input logic e,
                            input logic [31:0] n);
    out_item_t r;
    r.kind          = k;
    r.payload       = b;
    r.record_end    = e;
    r.record_number = n;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic deframe_request(input in_item_t req);
    int    p;
    kind_t k;
    p = int'(hdr_pos);
    if (req.has_byte) begin
      case (st_phase)
        PH_HEADER: begin
          if (p < HDR_LEN && req.stream_byte == MAGIC[8*(5-p) +: 8]) begin
            hdr_pos = hdr_pos + 3'd1;
            if (int'(hdr_pos) == HDR_LEN) next_record();
          end else begin
            st_phase = PH_BAD_HEADER;
          end
        end
        PH_LENGTH: begin
          len_acc  = {len_acc[23:0], req.stream_byte};
          len_seen = len_seen + 3'd1;
          if (int'(len_seen) >= LEN_BYTES) begin
            bytes_left = len_acc;
            if (bytes_left == 32'd0) begin
              add_result(KIND_EMPTY, 8'h00, 1'b1, rec_count);
              rec_count = rec_count + 32'd1;
              next_record();
            end else begin
              st_phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_left = bytes_left - 32'd1;
          add_result(KIND_BYTE, req.stream_byte, bytes_left == 32'd0, rec_count);
          if (bytes_left == 32'd0) begin
            rec_count = rec_count + 32'd1;
            next_record();
          end
        end
        default: ;
      endcase
    end
    if (req.end_of_stream) begin
      if (st_phase == PH_HEADER || st_phase == PH_BAD_HEADER) k = KIND_BAD_HEADER;
      else if (st_phase == PH_PAYLOAD) k = KIND_TRUNCATED;
      else if (st_phase == PH_LENGTH && len_seen != 3'd0) k = KIND_TRUNCATED;
      else k = KIND_OK;
      add_result(k, 8'h00, 1'b0, rec_count);
      clear_stream_state();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream_state();
      rec_limit = 32'd0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none", $time);
          $display("%0t:           actual kind %0d payload %02h end %0b number %0d",
                   $time, out_item.kind, out_item.payload, out_item.record_end,
                   out_item.record_number);
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind !== want.kind || out_item.payload !== want.payload ||
              out_item.record_end !== want.record_end ||
              out_item.record_number !== want.record_number) begin
            $display("%0t: mismatch: expected kind %0d payload %02h end %0b number %0d",
                     $time, want.kind, want.payload, want.record_end, want.record_number);
            $display("%0t:           actual kind %0d payload %02h end %0b number %0d",
                     $time, out_item.kind, out_item.payload, out_item.record_end,
                     out_item.record_number);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) rec_limit = cfg_data;
      if (in_valid && in_ready) deframe_request(in_item);
    end
    pending = expected_results.size();
  end

endmodule

FILE: dv/length_prefixed_record_deframer_tb.sv
// ---------------------------------------------------------------------------
// length_prefixed_record_deframer_tb
// Drives byte-stream requests into the deframer: a short directed opening,
// then phases of random streams (well-formed record runs, header mismatches,
// short headers, truncated lengths and payloads, noise) under several record
// limits, with random gaps on both channels. A checker module predicts and
// compares; this top gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_record_deframer_tb;
  import lprd_pkg::*;

  localparam logic [47:0] MAGIC       = 48'h4D534D503100;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          PHASE_REQS  = 105;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  int               fail_count;
  int               pending;
  int               quiet;
  int               phase_reqs;
  int               stream_no;
  bit               sprinkle;
  bit               tx_calm;
  bit               rx_calm;

  in_item_t         stream_q [$];
  logic [31:0]      limit_plan [0:6];

  length_prefixed_record_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  length_prefixed_record_deframer_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic logic [7:0] magic_at(input int p);
    return MAGIC[8*(5-p) +: 8];
  endfunction

  // receiver: bursts of ready with random stalls
  initial begin
    int burst;
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      burst = $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (burst) @(negedge clk);
      if (!rx_calm) begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
        $display("** length_prefixed_record_deframer: FAILED **");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic push_raw(input logic has, input logic [7:0] b, input logic eos);
    in_item_t t;
    t.has_byte      = has;
    t.stream_byte   = b;
    t.end_of_stream = eos;
    stream_q.insert(stream_q.size(), t);
  endtask

  task automatic push_data(input logic [7:0] b);
    if (sprinkle && $urandom_range(19) == 0) push_raw(1'b0, rand_byte(), 1'b0);
    push_raw(1'b1, b, 1'b0);
  endtask

  task automatic push_header(input int n);
    for (int i = 0; i < n; i++) push_data(magic_at(i));
  endtask

  task automatic push_length(input logic [31:0] len);
    push_data(len[31:24]);
    push_data(len[23:16]);
    push_data(len[15:8]);
    push_data(len[7:0]);
  endtask

  task automatic push_record(input logic [31:0] len);
    push_length(len);
    for (int i = 0; i < int'(len); i++) push_data(rand_byte());
  endtask

  function automatic logic [31:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 32'd0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 16);
    return $urandom_range(17, 64);
  endfunction

  // end marker either rides on the last byte or stands alone
  task automatic close_stream();
    in_item_t t;
    int       last;
    last = stream_q.size() - 1;
    if (last >= 0 && $urandom_range(1) == 1) begin
      t = stream_q[last];
      if (t.has_byte && !t.end_of_stream) begin
        t.end_of_stream = 1'b1;
        stream_q[last] = t;
        return;
      end
    end
    push_raw(1'b0, rand_byte(), 1'b1);
  endtask

  task automatic build_stream();
    int          sel;
    int          n;
    int          pos;
    logic [7:0]  b;
    logic [31:0] len;
    sel = $urandom_range(99);
    if (sel < 60) begin
      push_header(6);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) push_record(pick_len());
    end else if (sel < 68) begin
      pos = $urandom_range(0, 5);
      push_header(pos);
      b = rand_byte();
      if (b == magic_at(pos)) b = b ^ 8'h01;
      push_data(b);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) push_data(rand_byte());
    end else if (sel < 74) begin
      push_header($urandom_range(0, 5));
    end else if (sel < 84) begin
      push_header(6);
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) push_record(pick_len());
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) push_data(rand_byte());
    end else if (sel < 94) begin
      push_header(6);
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) push_record(pick_len());
      len = $urandom;
      if (len < 32'd8) len = 32'd8;
      push_length(len);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) push_data(rand_byte());
    end else begin
      push_header(6);
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) push_data(rand_byte());
    end
    close_stream();
  endtask

  task automatic send_item(input in_item_t t);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic send_stream();
    in_item_t t;
    while (stream_q.size() > 0) begin
      t = stream_q.pop_front();
      if (t.has_byte || t.end_of_stream) phase_reqs++;
      send_item(t);
    end
  endtask

  task automatic release_input();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    release_input();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    quiet      = 0;
    sprinkle   = 1'b0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    phase_reqs = 0;
    limit_plan[0] = 32'hFFFF_FFFF;
    limit_plan[1] = 32'd1;
    limit_plan[2] = 32'd0;
    limit_plan[3] = 32'd2;
    limit_plan[4] = $urandom_range(3, 6);
    limit_plan[5] = 32'd3;
    limit_plan[6] = $urandom;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_limit(32'd0);
    // good stream: empty record, one-byte record closed by its last byte
    push_header(6);
    push_record(32'd0);
    push_length(32'd1);
    push_raw(1'b1, 8'hFF, 1'b1);
    push_raw(1'b0, 8'hA5, 1'b0);
    // short header, then mismatch with a dropped byte, then bare end alone
    push_header(1);
    push_raw(1'b0, 8'h5A, 1'b1);
    push_header(2);
    push_raw(1'b1, 8'h00, 1'b0);
    push_raw(1'b1, 8'hFF, 1'b1);
    push_raw(1'b0, 8'hFF, 1'b1);
    send_stream();

    sprinkle = 1'b1;
    for (int ph = 0; ph < 7; ph++) begin
      write_limit(limit_plan[ph]);
      tx_calm    = (ph == 2);
      rx_calm    = (ph == 4);
      phase_reqs = 0;
      stream_no  = 0;
      while (phase_reqs < PHASE_REQS) begin
        if (stream_no % 13 == 6) wait_drained();
        build_stream();
        send_stream();
        stream_no++;
      end
    end

    wait_drained();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** length_prefixed_record_deframer: PASSED **");
    end else begin
      $display("** length_prefixed_record_deframer: FAILED **");
    end
    $finish;
  end

endmodule
